FILE: hw/rtl/bounded_ordered_list_engine_core_assert.svh
// Assertion macros for the ordered list engine.
`ifndef BOUNDED_ORDERED_LIST_ENGINE_CORE_ASSERT_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define BOLE_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BOLE_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define BOLE_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define BOLE_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

FILE: hw/rtl/bole_pkg.sv
package bole_pkg;
	typedef enum logic [3:0] {
		REQ_PUSH_FRONT = 4'd0,
		REQ_PUSH_BACK  = 4'd1,
		REQ_INSERT_AFT = 4'd2,
		REQ_POP_FRONT  = 4'd3,
		REQ_POP_BACK   = 4'd4,
		REQ_DELETE_AT  = 4'd5,
		REQ_SEARCH     = 4'd6,
		REQ_CLEAR      = 4'd7,
		REQ_DISPLAY    = 4'd8
	} req_t;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_EMPTY    = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_RANGE    = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SHOW,
		S_SCAN
	} state_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_INSERT,
		OP_REMOVE,
		OP_CLEAR
	} op_t;

	// Controller to datapath.
	typedef struct packed {
		op_t  op;
		logic load_req;
		logic scan_start;
		logic scan_step;
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic scan_last;
	} dp_status_t;

	typedef struct packed {
		logic [3:0]         req_type;
		logic signed [31:0] item_value;
		logic [4:0]         item_position;
	} req_word_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] out_value;
		logic [3:0]         found_index;
		logic [4:0]         occupancy;
		logic               last_of_run;
	} rsp_word_t;
endpackage

FILE: hw/rtl/bole_req_if.sv
interface bole_req_if import bole_pkg::*; ();
	logic      valid;
	logic      ready;
	req_word_t word;
	modport source (output valid, output word, input ready);
	modport sink (input valid, input word, output ready);
endinterface

FILE: hw/rtl/bole_rsp_if.sv
interface bole_rsp_if import bole_pkg::*; ();
	logic      valid;
	logic      ready;
	rsp_word_t word;
	modport source (output valid, output word, input ready);
	modport sink (input valid, input word, output ready);
endinterface

FILE: hw/rtl/bounded_ordered_list_engine_core.sv
// Ordered list engine: keeps up to DEPTH signed 32-bit values in a row of
// shifting cells, front at cell zero. Each request word gives exactly one
// response word, except display, which gives one word per element (or one
// word with status empty), the last marked by last_of_run. A request is
// registered; once the response register is free, the cells shift and
// the response is loaded; display then adds one word per further element,
// paced by the single read of the cell row. Search compares all cells at
// once. Request codes above display are dropped without a response. The
// response register frees the input side while a word waits downstream.
`include "bounded_ordered_list_engine_core_assert.svh"
module bounded_ordered_list_engine_core import bole_pkg::*; #(
	parameter int DEPTH = 16
) (
	input logic        clk,
	input logic        arst_n,
	bole_req_if.sink   req,
	bole_rsp_if.source rsp
);
	dp_cmd_t    cmd;
	dp_status_t dp_status;
	rsp_word_t  resp_c;
	logic       resp_load;
	logic       out_free;
	logic [4:0] occ;
	logic       rsp_valid_q;
	rsp_word_t  rsp_word_q;

	// The response register may be reloaded once its word is taken.
	assign out_free = !rsp_valid_q || rsp.ready;

	bole_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_type   (req.word.req_type),
		.in_ready  (req.ready),
		.out_free  (out_free),
		.resp_last (resp_c.last_of_run),
		.status    (dp_status),
		.cmd       (cmd),
		.resp_load (resp_load)
	);

	bole_dp #(.DEPTH(DEPTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req.word),
		.cmd       (cmd),
		.status    (dp_status),
		.resp      (resp_c),
		.occupancy (occ)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (resp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (resp_load) rsp_word_q <= resp_c;
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.word  = rsp_word_q;

	// Occupancy never exceeds the depth.
	`BOLE_ASSERT_NEVER(a_occ_bound, clk, arst_n, (32'(occ) > DEPTH), "occupancy above depth")
	// A response is only loaded when the output register is free.
	`BOLE_ASSERT_NEVER(a_no_overwrite, clk, arst_n, (resp_load && !out_free), "response overwritten")
	// Occupancy in a fresh response matches the element count in the cycle after the load.
	`BOLE_ASSERT_IMPL(a_occ_match, clk, arst_n, (resp_load |=> (rsp_word_q.occupancy == occ)), "occupancy mismatch")
endmodule

FILE: hw/rtl/bole_ctrl.sv
module bole_ctrl import bole_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [3:0] in_type,
	output logic       in_ready,
	input  logic       out_free,
	input  logic       resp_last,
	input  dp_status_t status,
	output dp_cmd_t    cmd,
	output logic       resp_load
);
	state_t state_q, state_d;
	req_t   req_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			req_q   <= REQ_CLEAR;
		end else begin
			state_q <= state_d;
			if (in_valid && in_ready) req_q <= req_t'(in_type);
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		cmd       = '{op: OP_NONE, load_req: 1'b0, scan_start: 1'b0, scan_step: 1'b0};
		resp_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready     = 1'b1;
				cmd.load_req = in_valid;
				if (in_valid && in_type <= 4'(REQ_DISPLAY)) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (out_free) begin
					resp_load = 1'b1;
					cmd.op = OP_NONE;
					if (req_q == REQ_DISPLAY) begin
						cmd.scan_start = 1'b1;
						state_d = resp_last ? S_IDLE : S_SCAN;
					end else begin
						state_d = S_IDLE;
						priority case (req_q)
							REQ_PUSH_FRONT, REQ_PUSH_BACK, REQ_INSERT_AFT: cmd.op = OP_INSERT;
							REQ_POP_FRONT, REQ_POP_BACK, REQ_DELETE_AT:    cmd.op = OP_REMOVE;
							REQ_CLEAR:                                     cmd.op = OP_CLEAR;
							default:                                       cmd.op = OP_NONE;
						endcase
					end
				end
			end
			S_SCAN: begin
				if (out_free) begin
					resp_load     = 1'b1;
					cmd.scan_step = 1'b1;
					if (status.scan_last) state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

FILE: hw/rtl/bole_dp.sv
module bole_dp import bole_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  req_word_t  req,
	input  dp_cmd_t    cmd,
	output dp_status_t status,
	output rsp_word_t  resp,
	output logic [4:0] occupancy
);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic signed [31:0] cell_q [DEPTH];
	logic [CW-1:0]      count_q;
	req_word_t          req_q;
	logic [CW-1:0]      scan_q;
	logic               ok_op;
	logic [CW-1:0]      at;
	logic [DEPTH-1:0]   hit;
	logic [IW-1:0]      hit_idx;
	logic               hit_any;
	logic [CW-1:0]      pos_c;
	logic [CW-1:0]      scan_idx;

	assign pos_c = CW'(req_q.item_position);

	// Match vector over the valid cells; a priority encode picks the first hit.
	always_comb begin
		hit_idx = '0;
		hit_any = 1'b0;
		for (int i = 0; i < DEPTH; i++) begin
			hit[i] = (CW'(i) < count_q) && (cell_q[i] == req_q.item_value);
		end
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (hit[i]) begin
				hit_idx = IW'(i);
				hit_any = 1'b1;
			end
		end
	end

	// Result word and the cell where the insert or removal happens.
	always_comb begin
		resp = '{status: ST_OK, out_value: '0, found_index: '0,
			occupancy: '0, last_of_run: 1'b1};
		at = '0;
		ok_op = 1'b0;
		scan_idx = cmd.scan_step ? scan_q + CW'(1) : CW'(0);
		unique case (req_q.req_type)
			4'(REQ_PUSH_FRONT), 4'(REQ_PUSH_BACK): begin
				if (count_q >= CW'(DEPTH)) resp.status = ST_FULL;
				else ok_op = 1'b1;
				at = (req_q.req_type == 4'(REQ_PUSH_FRONT)) ? '0 : count_q;
			end
			4'(REQ_INSERT_AFT): begin
				if (count_q == '0) resp.status = ST_EMPTY;
				else if (count_q >= CW'(DEPTH)) resp.status = ST_FULL;
				else ok_op = 1'b1;
				at = (32'(req_q.item_position) >= 32'(count_q))
					? count_q : pos_c + CW'(1);
			end
			4'(REQ_POP_FRONT), 4'(REQ_POP_BACK): begin
				if (count_q == '0) resp.status = ST_EMPTY;
				else ok_op = 1'b1;
				at = (req_q.req_type == 4'(REQ_POP_FRONT)) ? '0 : count_q - CW'(1);
			end
			4'(REQ_DELETE_AT): begin
				if (count_q == '0) resp.status = ST_EMPTY;
				else if (req_q.item_position == '0 || 32'(req_q.item_position) > 32'(count_q))
					resp.status = ST_RANGE;
				else ok_op = 1'b1;
				at = pos_c - CW'(1);
			end
			4'(REQ_SEARCH): begin
				if (count_q == '0) resp.status = ST_EMPTY;
				else if (!hit_any) resp.status = ST_NOTFOUND;
				else begin
					resp.out_value   = req_q.item_value;
					resp.found_index = 4'(hit_idx);
				end
			end
			4'(REQ_CLEAR): ;
			4'(REQ_DISPLAY): begin
				if (count_q == '0) resp.status = ST_EMPTY;
				else begin
					resp.out_value   = cell_q[scan_idx[IW-1:0]];
					resp.found_index = 4'(scan_idx);
					resp.last_of_run = (scan_idx + CW'(1) == count_q);
				end
			end
			default: ;
		endcase
		if (ok_op && (req_q.req_type == 4'(REQ_POP_FRONT) || req_q.req_type == 4'(REQ_POP_BACK)
			|| req_q.req_type == 4'(REQ_DELETE_AT)))
			resp.out_value = cell_q[at[IW-1:0]];
		if (req_q.req_type == 4'(REQ_CLEAR)) resp.occupancy = '0;
		else if (ok_op && cmd.op == OP_INSERT) resp.occupancy = 5'(count_q + CW'(1));
		else if (ok_op && cmd.op == OP_REMOVE) resp.occupancy = 5'(count_q - CW'(1));
		else resp.occupancy = 5'(count_q);
	end

	assign status.scan_last = (scan_q + CW'(2) >= count_q);
	assign occupancy = 5'(count_q);

	// Shifting cells: each cell takes its own value, its left or its right neighbor, or the new item.
	always_ff @(posedge clk) begin
		if (cmd.load_req) req_q <= req;
		if (ok_op && cmd.op == OP_INSERT) begin
			for (int i = 0; i < DEPTH; i++) begin
				if (CW'(i) == at) cell_q[i] <= req_q.item_value;
				else if (CW'(i) > at && i > 0) cell_q[i] <= cell_q[(i > 0) ? i - 1 : 0];
			end
		end else if (ok_op && cmd.op == OP_REMOVE) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				if (CW'(i) >= at) cell_q[i] <= cell_q[i + 1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			scan_q  <= '0;
		end else begin
			if (cmd.op == OP_CLEAR) count_q <= '0;
			else if (ok_op && cmd.op == OP_INSERT) count_q <= count_q + CW'(1);
			else if (ok_op && cmd.op == OP_REMOVE) count_q <= count_q - CW'(1);
			if (cmd.scan_start) scan_q <= '0;
			else if (cmd.scan_step) scan_q <= scan_q + CW'(1);
		end
	end
endmodule

FILE: tb/bole_tb_if.sv
`timescale 1ns / 1ps
// Channel interfaces come from the RTL; this file holds a small shared constant for the bench.
package bole_tb_pkg;
	import bole_pkg::*;
	localparam int LIST_DEPTH = 16;
endpackage

FILE: tb/bole_list_checker.sv
`timescale 1ns / 1ps
module bole_list_checker import bole_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	bole_req_if       req,
	bole_rsp_if       rsp,
	output int        fail_count,
	output int        pending_words
);
	localparam int DEPTH = bole_tb_pkg::LIST_DEPTH;

	logic signed [31:0] cells [DEPTH];
	int                 count;
	rsp_word_t          expected_q [$];

	initial fail_count = 0;
	assign pending_words = expected_q.size();

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		fail_count++;
	endtask

	function automatic rsp_word_t make_word(logic [2:0] st, logic signed [31:0] v,
		int idx, logic last);
		rsp_word_t w;
		w.status = st;
		w.out_value = v;
		w.found_index = idx[3:0];
		w.occupancy = count[4:0];
		w.last_of_run = last;
		return w;
	endfunction

	function automatic void insert_at(int at, logic signed [31:0] v);
		for (int i = count; i > at; i--)
			cells[i] = cells[i - 1];
		cells[at] = v;
		count++;
	endfunction

	function automatic logic signed [31:0] remove_at(int at);
		logic signed [31:0] v;
		v = cells[at];
		for (int i = at; i + 1 < count; i++)
			cells[i] = cells[i + 1];
		count--;
		return v;
	endfunction

	// Applies one request word to the list copy and queues the words it produces.
	function automatic void predict_list_op(req_word_t r);
		int pos;
		int hit;
		logic signed [31:0] v;
		pos = int'(r.item_position);
		hit = -1;
		case (r.req_type)
			REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
				if (count >= DEPTH) expected_q.push_back(make_word(ST_FULL, 0, 0, 1));
				else begin
					insert_at(r.req_type == REQ_PUSH_FRONT ? 0 : count, r.item_value);
					expected_q.push_back(make_word(ST_OK, 0, 0, 1));
				end
			end
			REQ_INSERT_AFT: begin
				if (count == 0) expected_q.push_back(make_word(ST_EMPTY, 0, 0, 1));
				else if (count >= DEPTH) expected_q.push_back(make_word(ST_FULL, 0, 0, 1));
				else begin
					if (pos > count - 1) pos = count - 1;
					insert_at(pos + 1, r.item_value);
					expected_q.push_back(make_word(ST_OK, 0, 0, 1));
				end
			end
			REQ_POP_FRONT, REQ_POP_BACK: begin
				if (count == 0) expected_q.push_back(make_word(ST_EMPTY, 0, 0, 1));
				else begin
					v = remove_at(r.req_type == REQ_POP_FRONT ? 0 : count - 1);
					expected_q.push_back(make_word(ST_OK, v, 0, 1));
				end
			end
			REQ_DELETE_AT: begin
				if (count == 0) expected_q.push_back(make_word(ST_EMPTY, 0, 0, 1));
				else if (pos < 1 || pos > count)
					expected_q.push_back(make_word(ST_RANGE, 0, 0, 1));
				else begin
					v = remove_at(pos - 1);
					expected_q.push_back(make_word(ST_OK, v, 0, 1));
				end
			end
			REQ_SEARCH: begin
				if (count == 0) expected_q.push_back(make_word(ST_EMPTY, 0, 0, 1));
				else begin
					for (int i = count - 1; i >= 0; i--)
						if (cells[i] == r.item_value) hit = i;
					if (hit < 0) expected_q.push_back(make_word(ST_NOTFOUND, 0, 0, 1));
					else expected_q.push_back(make_word(ST_OK, r.item_value, hit, 1));
				end
			end
			REQ_CLEAR: begin
				count = 0;
				expected_q.push_back(make_word(ST_OK, 0, 0, 1));
			end
			REQ_DISPLAY: begin
				if (count == 0) expected_q.push_back(make_word(ST_EMPTY, 0, 0, 1));
				else for (int i = 0; i < count; i++)
					expected_q.push_back(make_word(ST_OK, cells[i], i, i + 1 == count));
			end
			default: ;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_word_t e;
		if (!arst_n) begin
			count = 0;
			expected_q.delete();
		end else begin
			// The response side is checked before the request side, since a word
			// accepted now can only produce responses at later edges.
			if (rsp.valid && rsp.ready) begin
				if (expected_q.size() == 0)
					report_mismatch("response word with nothing expected");
				else begin
					e = expected_q.pop_front();
					if (rsp.word.status !== e.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							rsp.word.status, e.status));
					if (rsp.word.out_value !== e.out_value)
						report_mismatch($sformatf("out_value %0d, expected %0d",
							rsp.word.out_value, e.out_value));
					if (rsp.word.found_index !== e.found_index)
						report_mismatch($sformatf("found_index %0d, expected %0d",
							rsp.word.found_index, e.found_index));
					if (rsp.word.occupancy !== e.occupancy)
						report_mismatch($sformatf("occupancy %0d, expected %0d",
							rsp.word.occupancy, e.occupancy));
					if (rsp.word.last_of_run !== e.last_of_run)
						report_mismatch($sformatf("last_of_run %0b, expected %0b",
							rsp.word.last_of_run, e.last_of_run));
				end
			end
			if (req.valid && req.ready)
				predict_list_op(req.word);
		end
	end
endmodule

FILE: tb/bounded_ordered_list_engine_core_tb.sv
`timescale 1ns / 1ps
module bounded_ordered_list_engine_core_tb;
	import bole_pkg::*;

	localparam int DEPTH       = 16;
	localparam int CYCLE_LIMIT = 1000000;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending_words;
	int   cycle_count;

	// The receiver stalls at random in stall mode; hold_rsp forces a long stall so
	// that the engine fills its response register and backs up its input.
	logic hold_rsp;
	logic stall_mode;

	bole_req_if req_ch ();
	bole_rsp_if rsp_ch ();

	bounded_ordered_list_engine_core #(.DEPTH(DEPTH)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.rsp(rsp_ch.source)
	);

	bole_list_checker checker_inst (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.fail_count(fail_count),
		.pending_words(pending_words)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Run limit: a hang anywhere ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("== FAIL ==");
			$finish;
		end
	end

	// Response-side ready. In stall mode each word gets its own randomly drawn wait;
	// in the calm stretch the wait is zero so that back-to-back transfers occur.
	initial begin
		int wait_cycles;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_rsp) begin
				rsp_ch.ready <= 1'b0;
			end else if (rsp_ch.ready && rsp_ch.valid) begin
				wait_cycles = stall_mode ? $urandom_range(0, 18) : 0;
				if (wait_cycles != 0) begin
					rsp_ch.ready <= 1'b0;
					repeat (wait_cycles - 1) @(posedge clk);
					@(posedge clk);
					rsp_ch.ready <= 1'b1;
				end
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Offers one request word and holds it until the engine takes it.
	task automatic send_word(input logic [3:0] kind, input logic signed [31:0] v,
		input logic [4:0] pos, input bit gaps);
		int gap;
		gap = gaps ? $urandom_range(0, 18) : 0;
		repeat (gap) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.word.req_type <= kind;
		req_ch.word.item_value <= v;
		req_ch.word.item_position <= pos;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// Ends a burst: drops valid and waits for every expected word to come back.
	task automatic drain_words();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_words != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// Values drawn from a small pool repeat often enough for search hits,
	// with occasional extremes and full-width random values.
	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return $urandom();
			default: return $signed($urandom_range(0, 7)) - 3;
		endcase
	endfunction

	// Weighted toward inserts so the list spends time near full as well as empty.
	function automatic logic [3:0] pick_kind();
		int r;
		r = $urandom_range(0, 99);
		if (r < 18) return REQ_PUSH_FRONT;
		if (r < 36) return REQ_PUSH_BACK;
		if (r < 50) return REQ_INSERT_AFT;
		if (r < 58) return REQ_POP_FRONT;
		if (r < 66) return REQ_POP_BACK;
		if (r < 76) return REQ_DELETE_AT;
		if (r < 88) return REQ_SEARCH;
		if (r < 90) return REQ_CLEAR;
		if (r < 97) return REQ_DISPLAY;
		return 4'($urandom_range(9, 15));
	endfunction

	initial begin
		cycle_count = 0;
		hold_rsp = 1'b0;
		stall_mode = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.word = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: every empty-list error, then fill to full, probe the
		// full and range errors, search hit and miss, display, and clear.
		send_word(REQ_POP_FRONT, 0, 0, 0);
		send_word(REQ_POP_BACK, 0, 0, 0);
		send_word(REQ_DELETE_AT, 0, 1, 0);
		send_word(REQ_INSERT_AFT, 5, 0, 0);
		send_word(REQ_SEARCH, 5, 0, 0);
		send_word(REQ_DISPLAY, 0, 0, 0);
		send_word(REQ_PUSH_BACK, 32'sh7FFF_FFFF, 0, 0);
		send_word(REQ_PUSH_FRONT, 32'sh8000_0000, 0, 0);
		send_word(REQ_INSERT_AFT, -1, 5'd31, 0);
		send_word(REQ_INSERT_AFT, 42, 0, 0);
		for (int i = 0; i < 12; i++)
			send_word(REQ_PUSH_BACK, i, 0, 0);
		send_word(REQ_PUSH_FRONT, 99, 0, 0);
		send_word(REQ_INSERT_AFT, 99, 3, 0);
		send_word(REQ_DISPLAY, 0, 0, 0);
		send_word(REQ_SEARCH, 11, 0, 0);
		send_word(REQ_SEARCH, 1234, 0, 0);
		send_word(REQ_DELETE_AT, 0, 0, 0);
		send_word(REQ_DELETE_AT, 0, 17, 0);
		send_word(REQ_DELETE_AT, 0, 16, 0);
		send_word(REQ_DELETE_AT, 0, 3, 0);
		send_word(REQ_PUSH_BACK, 0, 0, 0);
		send_word(4'd15, 0, 0, 0);
		send_word(REQ_CLEAR, 0, 0, 0);
		send_word(REQ_DISPLAY, 0, 0, 0);
		// The sender pauses here until every expected word has come back.
		drain_words();

		// Long receiver stall while the sender keeps offering words.
		fork
			begin
				hold_rsp = 1'b1;
				repeat (300) @(posedge clk);
				hold_rsp = 1'b0;
			end
			for (int i = 0; i < 20; i++)
				send_word(i % 3 == 0 ? REQ_DISPLAY : REQ_PUSH_BACK, pick_value(),
					5'($urandom()), 0);
		join
		drain_words();

		// Random part: phases with and without idling on both sides.
		for (int n = 0; n < 275; n++) begin
			if (n % 60 == 0) stall_mode = ~stall_mode;
			send_word(pick_kind(), pick_value(), 5'($urandom()), stall_mode);
		end
		drain_words();

		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
